// ===== src/rpd_pkg.sv =====
// Package for the packet deframer: field widths, phase and status codes,
// the result and configuration structs and the hex digit decoder.
// Depends on nothing; every other file refers to it by scoped names.
package rpd_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 13;
	localparam int NIB_W       = 4;
	localparam int MAX_PAYLOAD = 4096;

	localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(MAX_PAYLOAD);

	// APB register map.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_BREAK_CHAR    = 1'b0;
	localparam logic REG_PAYLOAD_LIMIT = 1'b1;

	localparam logic [BYTE_W-1:0] BREAK_CHAR_RESET    = 8'd3;
	localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RESET = 13'd4096;

	localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_HI      = 2'd2;
	localparam logic [1:0] PH_LO      = 2'd3;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_TAKEN = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;
	localparam logic [1:0] ST_BREAK = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] break_char;
		logic [LEN_W-1:0]  payload_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_byte;
		logic              ack_req;
		logic              nak_req;
		logic [LEN_W-1:0]  frame_length;
	} result_t;

	typedef struct packed {
		logic             ok;
		logic [NIB_W-1:0] value;
	} digit_t;

	// Decodes one ASCII hex digit in either case.
	function automatic digit_t hex_digit(input logic [BYTE_W-1:0] c);
		digit_t d;
		d.ok    = 1'b1;
		d.value = '0;
		if (c inside {[8'h30:8'h39]}) begin
			d.value = c[NIB_W-1:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			d.value = c[NIB_W-1:0] + 4'd9;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// ===== src/rpd_if.sv =====
// Valid/ready stream interfaces for received bytes and deframer results.
// Depends on rpd_pkg for field widths.
interface rpd_in_if;
	logic                      valid;
	logic                      ready;
	logic [rpd_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface rpd_out_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic                       payload_valid;
	logic [rpd_pkg::BYTE_W-1:0] payload_byte;
	logic                       ack_req;
	logic                       nak_req;
	logic [rpd_pkg::LEN_W-1:0]  frame_length;

	modport source (output valid, output status, output payload_valid, output payload_byte,
		output ack_req, output nak_req, output frame_length, input ready);
	modport sink (input valid, input status, input payload_valid, input payload_byte,
		input ack_req, input nak_req, input frame_length, output ready);
endinterface

// ===== src/rpd_cfg.sv =====
// APB configuration registers of the deframer: break character and payload limit.
// Depends on rpd_pkg for the register map and reset values.
module rpd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rpd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rpd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output rpd_pkg::cfg_t                  cfg
);

	logic [rpd_pkg::BYTE_W-1:0] break_char_q;
	logic [rpd_pkg::LEN_W-1:0]  payload_limit_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_char_q    <= rpd_pkg::BREAK_CHAR_RESET;
			payload_limit_q <= rpd_pkg::PAYLOAD_LIMIT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				rpd_pkg::REG_BREAK_CHAR:    break_char_q    <= pwdata[rpd_pkg::BYTE_W-1:0];
				rpd_pkg::REG_PAYLOAD_LIMIT: payload_limit_q <= pwdata[rpd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rpd_pkg::REG_BREAK_CHAR:
				prdata = rpd_pkg::APB_DATA_W'(break_char_q);
			rpd_pkg::REG_PAYLOAD_LIMIT:
				prdata = rpd_pkg::APB_DATA_W'(payload_limit_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.break_char    = break_char_q;
	assign cfg.payload_limit = payload_limit_q;

endmodule

// ===== src/rpd_core.sv =====
// Deframer state and per-byte decision logic, ending in the result register.
// Depends on rpd_pkg for codes, structs and the hex digit decoder.
module rpd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rpd_pkg::cfg_t              cfg,
	input  logic                       valid_s1,
	input  logic [rpd_pkg::BYTE_W-1:0] byte_s1,
	input  logic                       advance,
	output logic                       valid_s2,
	output rpd_pkg::result_t           res_s2
);

	logic [1:0]                 phase_q, phase_d;
	logic [rpd_pkg::LEN_W-1:0]  count_q, count_d;
	logic [rpd_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic [rpd_pkg::NIB_W-1:0]  hi_q, hi_d;
	logic [rpd_pkg::LEN_W-1:0]  limit;
	rpd_pkg::digit_t            dig;
	rpd_pkg::result_t           res;
	logic                       fire;

	assign fire  = valid_s1 && advance;
	assign dig   = rpd_pkg::hex_digit(byte_s1);
	assign limit = (cfg.payload_limit > rpd_pkg::LIMIT_MAX) ? rpd_pkg::LIMIT_MAX
		: cfg.payload_limit;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		sum_d   = sum_q;
		hi_d    = hi_q;
		res     = '0;
		case (phase_q)
			rpd_pkg::PH_IDLE: begin
				// A dollar opens a frame even when it is also the break character.
				if (byte_s1 == rpd_pkg::CHAR_DOLLAR) begin
					phase_d    = rpd_pkg::PH_PAYLOAD;
					count_d    = '0;
					sum_d      = '0;
					hi_d       = '0;
					res.status = rpd_pkg::ST_TAKEN;
				end else if (byte_s1 == cfg.break_char) begin
					res.status = rpd_pkg::ST_BREAK;
				end
			end
			rpd_pkg::PH_PAYLOAD: begin
				if (byte_s1 == rpd_pkg::CHAR_HASH) begin
					phase_d    = rpd_pkg::PH_HI;
					res.status = rpd_pkg::ST_TAKEN;
				end else if (count_q >= limit) begin
					res.nak_req = 1'b1;
					phase_d     = rpd_pkg::PH_IDLE;
					count_d     = '0;
					sum_d       = '0;
					hi_d        = '0;
				end else begin
					count_d           = count_q + 1'b1;
					sum_d             = sum_q + byte_s1;
					res.payload_valid = 1'b1;
					res.payload_byte  = byte_s1;
					res.status        = rpd_pkg::ST_TAKEN;
				end
			end
			rpd_pkg::PH_HI: begin
				if (!dig.ok) begin
					res.nak_req = 1'b1;
					phase_d     = rpd_pkg::PH_IDLE;
					count_d     = '0;
					sum_d       = '0;
					hi_d        = '0;
				end else begin
					hi_d       = dig.value;
					phase_d    = rpd_pkg::PH_LO;
					res.status = rpd_pkg::ST_TAKEN;
				end
			end
			default: begin
				if (dig.ok && {hi_q, dig.value} == sum_q) begin
					res.ack_req      = 1'b1;
					res.frame_length = count_q;
					res.status       = rpd_pkg::ST_DONE;
				end else begin
					res.nak_req = 1'b1;
				end
				phase_d = rpd_pkg::PH_IDLE;
				count_d = '0;
				sum_d   = '0;
				hi_d    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rpd_pkg::PH_IDLE;
			count_q  <= '0;
			sum_q    <= '0;
			hi_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				count_q <= count_d;
				sum_q   <= sum_d;
				hi_q    <= hi_d;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== src/rsp_packet_deframer.sv =====
// Remote serial protocol packet deframer: one result for every received byte.
// A byte accepted on rx is registered in byte_s1 and its result in res_s2, which
// drives tx; while tx stalls, the result register and a full byte_s1 hold.
// Throughput: one byte per cycle unless tx stalls, set by rpd_core's state update.
// Reset (arst_n, asynchronous): idle phase, count, sum and nibble cleared,
// pipeline empty, registers at break character 3 and payload limit 4096.
module rsp_packet_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	rpd_in_if.sink                         rx,
	rpd_out_if.source                      tx,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rpd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rpd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	rpd_pkg::cfg_t              cfg;
	rpd_pkg::result_t           res_s2;
	logic                       valid_s1;
	logic [rpd_pkg::BYTE_W-1:0] byte_s1;
	logic                       valid_s2;
	logic                       advance;

	rpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register moves whenever it is empty or its transfer completes.
	assign advance  = !valid_s2 || tx.ready;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.in_byte;
		end
	end

	rpd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.advance  (advance),
		.valid_s2 (valid_s2),
		.res_s2   (res_s2)
	);

	assign tx.valid         = valid_s2;
	assign tx.status        = res_s2.status;
	assign tx.payload_valid = res_s2.payload_valid;
	assign tx.payload_byte  = res_s2.payload_byte;
	assign tx.ack_req       = res_s2.ack_req;
	assign tx.nak_req       = res_s2.nak_req;
	assign tx.frame_length  = res_s2.frame_length;

endmodule
